// ===== src/unsigned_decimal_formatter_assert.svh =====
// Assertion macros used by the unsigned decimal formatter datapath.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef UNSIGNED_DECIMAL_FORMATTER_ASSERT_SVH
`define UNSIGNED_DECIMAL_FORMATTER_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define UDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form: when the trigger holds, the consequence holds in the next cycle.
`define UDF_ASSERT_NEXT(lbl, trig, cons, msg) \
  `UDF_ASSERT(lbl, (trig) |=> (cons), msg)

`endif

// ===== src/udf_pkg.sv =====
// Package for the unsigned decimal formatter: constants, controller state type
// and the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package udf_pkg;

  // Widest conversion, in characters.
  localparam logic [6:0] MAX_CHARS = 7'd64;

  // ASCII codes used for padding and digits.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // A 32-bit value has at most ten decimal digits.
  localparam int unsigned NUM_DIGITS = 10;

  // floor(n / 10) == (n * RECIP_TEN) >> RECIP_SHIFT for every 32-bit n.
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_EMIT
  } udf_state_e;

  typedef struct packed {
    logic load;   // capture a new item
    logic step;   // peel off one decimal digit
    logic prep;   // work out body, padding and total length
    logic emit;   // move one character into the output register
  } udf_cmd_t;

  typedef struct packed {
    logic conv_last;   // the quotient of this digit step is zero
    logic total_zero;  // the conversion has no characters
    logic emit_last;   // the character at the current position is the final one
    logic out_free;    // the output register can take a character
  } udf_sts_t;

endpackage

`default_nettype wire

// ===== src/udf_if.sv =====
// Valid/ready channel interfaces for the unsigned decimal formatter.
// Depends on nothing; payload fields follow the item layout of the block.
`default_nettype none

interface udf_in_if;
  logic              valid;
  logic              ready;
  logic [31:0]       number;
  logic [6:0]        field_width;
  logic signed [7:0] precision;
  logic              left_align;
  logic              zero_pad;

  modport source (output valid, number, field_width, precision, left_align, zero_pad,
                  input ready);
  modport sink   (input valid, number, field_width, precision, left_align, zero_pad,
                  output ready);
endinterface

interface udf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;
  logic [6:0] total_chars;

  modport source (output valid, char_code, last, total_chars, input ready);
  modport sink   (input valid, char_code, last, total_chars, output ready);
endinterface

`default_nettype wire

// ===== src/udf_datapath.sv =====
// Datapath of the unsigned decimal formatter: digit extraction, field layout
// and output register. Depends on udf_pkg and the assertion macro header.
`default_nettype none

`include "unsigned_decimal_formatter_assert.svh"

module udf_datapath
  import udf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [31:0]       number_i,
  input  wire logic [6:0]        field_width_i,
  input  wire logic signed [7:0] precision_i,
  input  wire logic              left_align_i,
  input  wire logic              zero_pad_i,
  input  wire udf_cmd_t          cmd_i,
  output udf_sts_t               sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             char_code_o,
  output logic                   last_o,
  output logic [6:0]             total_chars_o
);

  // Captured item.
  logic [31:0] num_q;
  logic [6:0]  width_q;
  logic [6:0]  prec_q;
  logic        has_prec_q;
  logic        left_q;
  logic        zflag_q;
  logic        is_zero_q;

  // Digits, most significant at index 0 once extraction is done.
  logic [3:0]  digits_q [NUM_DIGITS];
  logic [3:0]  ndig_q;

  // Field layout.
  logic [6:0]  body_q;
  logic [6:0]  total_q;
  logic [6:0]  pad_q;
  logic [6:0]  lz_q;
  logic        zero_fill_q;
  logic [6:0]  pos_q;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic [6:0]  total_out_q;

  logic [63:0] prod;
  logic [28:0] quot;
  logic [31:0] quot_x10;
  logic [3:0]  rem;
  logic [6:0]  ndig_ext;
  logic [6:0]  body_d;
  logic [6:0]  total_d;
  logic [6:0]  k;
  logic [6:0]  didx;
  logic [7:0]  char_d;

  // Divide by ten through the reciprocal; the remainder is the next digit.
  assign prod     = 64'(num_q) * 64'(RECIP_TEN);
  assign quot     = prod[63:RECIP_SHIFT];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem      = 4'(num_q - quot_x10);

  assign ndig_ext = {3'b000, ndig_q};

  always_comb begin
    if (has_prec_q && (prec_q == 7'd0) && is_zero_q) begin
      body_d = 7'd0;
    end else if (has_prec_q && (prec_q > ndig_ext)) begin
      body_d = prec_q;
    end else begin
      body_d = ndig_ext;
    end
    total_d = (width_q > body_d) ? width_q : body_d;
  end

  // Character at the current position. Leading precision zeros come before the digits.
  always_comb begin
    k    = left_q ? pos_q : (pos_q - pad_q);
    didx = k - lz_q;
    if (!left_q && (pos_q < pad_q)) begin
      char_d = zero_fill_q ? CH_ZERO : CH_SPACE;
    end else if (left_q && (pos_q >= body_q)) begin
      char_d = CH_SPACE;
    end else if (k < lz_q) begin
      char_d = CH_ZERO;
    end else begin
      char_d = CH_ZERO | {4'h0, digits_q[didx[3:0]]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndig_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ndig_q <= '0;
      end else if (cmd_i.step) begin
        ndig_q <= ndig_q + 4'd1;
      end
      if (cmd_i.prep) begin
        pos_q <= '0;
      end else if (cmd_i.emit) begin
        pos_q <= pos_q + 7'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q      <= number_i;
      width_q    <= (field_width_i > MAX_CHARS) ? MAX_CHARS : field_width_i;
      has_prec_q <= ~precision_i[7];
      if (precision_i[7]) begin
        prec_q <= 7'd0;
      end else begin
        prec_q <= (precision_i[6:0] > MAX_CHARS) ? MAX_CHARS : precision_i[6:0];
      end
      left_q     <= left_align_i;
      zflag_q    <= zero_pad_i;
      is_zero_q  <= (number_i == 32'd0);
    end
    if (cmd_i.step) begin
      num_q       <= {3'b000, quot};
      digits_q[0] <= rem;
      for (int i = 1; i < NUM_DIGITS; i++) begin
        digits_q[i] <= digits_q[i-1];
      end
    end
    if (cmd_i.prep) begin
      body_q      <= body_d;
      total_q     <= total_d;
      pad_q       <= total_d - body_d;
      lz_q        <= body_d - ndig_ext;
      zero_fill_q <= zflag_q && !left_q && !has_prec_q;
    end
    if (cmd_i.emit) begin
      char_q      <= char_d;
      last_q      <= (pos_q == total_q - 7'd1);
      total_out_q <= total_q;
    end
  end

  assign sts_o.conv_last  = (quot == 29'd0);
  assign sts_o.total_zero = (total_d == 7'd0);
  assign sts_o.emit_last  = (pos_q == total_q - 7'd1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign char_code_o   = char_q;
  assign last_o        = last_q;
  assign total_chars_o = total_out_q;

  `UDF_ASSERT(a_ndig_bound, ndig_q <= 4'd10, "digit count ran past ten")
  `UDF_ASSERT(a_emit_in_range, cmd_i.emit |-> (pos_q < total_q), "emission ran past the field")
  `UDF_ASSERT(a_total_bound, cmd_i.prep |-> (total_d <= MAX_CHARS), "field longer than the limit")
  `UDF_ASSERT_NEXT(a_emit_shows, cmd_i.emit, out_valid_q, "emitted character not presented")

endmodule

`default_nettype wire

// ===== src/udf_ctrl.sv =====
// Controller of the unsigned decimal formatter: sequences capture, digit
// extraction, layout and emission. Depends on udf_pkg.
`default_nettype none

module udf_ctrl
  import udf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire udf_sts_t sts_i,
  output udf_cmd_t      cmd_o
);

  udf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (sts_i.conv_last) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = sts_i.total_zero ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CONV: cmd_o.step = 1'b1;
      ST_PREP: cmd_o.prep = 1'b1;
      ST_EMIT: cmd_o.emit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/unsigned_decimal_formatter.sv =====
// Top level of the unsigned decimal formatter (printf %u conversion).
// Depends on udf_pkg, udf_if, udf_ctrl and udf_datapath.
`default_nettype none

// One item is taken at a time. After acceptance the datapath peels off one
// decimal digit per cycle with a divide-by-ten unit, one step per digit of the
// value, then works out the field layout, and then moves one character per
// cycle into the output register whenever that register can take a character.
// The next item is accepted once the final character of the previous one sits
// in the output register. An item that yields no characters produces no
// transaction at all.
module unsigned_decimal_formatter
  import udf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  udf_in_if.sink    in_i,
  udf_out_if.source out_o
);

  udf_cmd_t cmd;
  udf_sts_t sts;

  udf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  udf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .number_i      (in_i.number),
    .field_width_i (in_i.field_width),
    .precision_i   (in_i.precision),
    .left_align_i  (in_i.left_align),
    .zero_pad_i    (in_i.zero_pad),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .char_code_o   (out_o.char_code),
    .last_o        (out_o.last),
    .total_chars_o (out_o.total_chars)
  );

endmodule

`default_nettype wire
